### hdl/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
`timescale 1ns / 1ps

package hbp_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = BYTE_W - 1;
  localparam int CNT_W        = 3;
  localparam int ACC_W        = PEND_W + CODE_W;
  localparam int MAX_RESULTS  = ACC_W / BYTE_W;
  localparam int BUF_W        = MAX_RESULTS * BYTE_W;
  localparam int BUF_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W        = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              status;
  } res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } entry_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic              hit;
  } lookup_t;

endpackage

### hdl/hbp_code_table.sv
// Code table memory with per-entry valid flags and a registered lookup.
`timescale 1ns / 1ps

module hbp_code_table
  import hbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_entry,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic             rd_in_range,
  output lookup_t          lookup
);

  entry_t                 mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid;
  entry_t                 rd_entry;
  logic                   rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_idx];
      rd_hit   <= rd_in_range && valid[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  assign lookup = '{code: rd_entry.code, length: rd_entry.length, hit: rd_hit};

endmodule

### hdl/hbp_packer.sv
// Bit accumulator, byte packing and result buffer.
`timescale 1ns / 1ps

module hbp_packer
  import hbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  logic    take_flush,
  input  lookup_t lookup,
  output logic    busy,
  output logic    res_valid,
  input  logic    res_stall,
  output res_t    res
);

  logic                 s1_valid;
  logic                 s1_flush;
  logic [PEND_W-1:0]    pending_bits;
  logic [CNT_W-1:0]     pending_count;
  logic [BUF_W-1:0]     buf_bytes;
  logic [BUF_CNT_W-1:0] buf_count;
  logic                 buf_err;

  logic [PEND_W-1:0]    pending_bits_next;
  logic [CNT_W-1:0]     pending_count_next;
  logic [BUF_W-1:0]     buf_bytes_next;
  logic [BUF_CNT_W-1:0] buf_count_next;
  logic                 buf_err_next;

  logic [ACC_W-1:0]     acc;
  logic [LEN_W-1:0]     total;
  logic [BUF_CNT_W-1:0] nbytes;
  logic                 res_take;
  logic                 s1_move;

  assign res_take = res_valid && !res_stall;
  assign s1_move  = s1_valid && ((buf_count == '0) ||
                    ((buf_count == BUF_CNT_W'(1)) && res_take));
  assign busy     = s1_valid && !s1_move;

  always_comb begin
    acc    = ACC_W'(pending_bits) | (ACC_W'(lookup.code) << pending_count);
    total  = LEN_W'(pending_count) + lookup.length;
    nbytes = BUF_CNT_W'(total[LEN_W-1:3]);

    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    buf_bytes_next     = '0;
    buf_count_next     = '0;
    buf_err_next       = 1'b0;

    if (s1_flush) begin
      buf_bytes_next     = BUF_W'(pending_bits);
      buf_count_next     = (pending_count != '0) ? BUF_CNT_W'(1) : '0;
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else if (!lookup.hit) begin
      buf_count_next = BUF_CNT_W'(1);
      buf_err_next   = 1'b1;
    end else begin
      buf_bytes_next     = acc[BUF_W-1:0];
      buf_count_next     = nbytes;
      pending_bits_next  = PEND_W'(acc >> {nbytes, 3'b000});
      pending_count_next = total[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
      buf_count     <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
        buf_count     <= buf_count_next;
      end else if (res_take) begin
        buf_count <= buf_count - BUF_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_flush <= take_flush;
    end
    if (s1_move) begin
      buf_bytes <= buf_bytes_next;
      buf_err   <= buf_err_next;
    end else if (res_take) begin
      buf_bytes <= buf_bytes >> BYTE_W;
    end
  end

  assign res_valid = (buf_count != '0);
  assign res = '{out_byte:    buf_bytes[BYTE_W-1:0],
                 last_of_run: (buf_count == BUF_CNT_W'(1)),
                 status:      buf_err};

endmodule

### hdl/huffman_bit_packer.sv
// Huffman bit packer top level: LSB-first encoder with a loadable code table.
//
// Requests arrive on req (req_valid / req_stall); packed bytes leave on res
// (res_valid / res_stall). A request is taken at a rising edge with valid
// high and stall low. A load request writes one table entry at once and
// gives no result. An encode request reads the table in its accept cycle
// into a registered lookup, is packed in the packing stage and then loads
// the result buffer, which offers its first byte; each further byte of the
// same request follows once the previous is taken. A flush request gives
// one byte if bits are pending. One request is taken per cycle while it
// yields at most one result and the receiver does not stall; a request
// yielding several results holds the next request in the packing stage
// until its last byte is taken, so a sustained stream of four-byte codes
// is limited by the one-byte-wide result register.
// Reset (rst, synchronous) marks every table entry not valid and empties the
// accumulator and the result buffer; no sweep is needed. While the receiver
// stalls, the current byte holds on res and req_stall rises once the packing
// stage has a request it cannot pass on.
`timescale 1ns / 1ps

module huffman_bit_packer
  import hbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic             req_take;
  logic             in_range;
  logic [LEN_W-1:0] len_clamped;
  logic             is_load;
  logic             is_work;
  entry_t           wr_entry;
  lookup_t          lookup;
  logic             busy;

  assign req_take = req_valid && !req_stall;
  assign req_stall = busy;

  assign in_range    = ({1'b0, req.symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
  assign len_clamped = (req.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                              : req.code_length;
  assign wr_entry = '{code:   req.code_bits & ~({CODE_W{1'b1}} << len_clamped),
                      length: len_clamped};

  assign is_load = (req.func == FUNC_LOAD);
  assign is_work = (req.func == FUNC_ENCODE) || (req.func == FUNC_FLUSH);

  hbp_code_table u_table (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (req_take && is_load && in_range),
    .wr_idx      (req.symbol[IDX_W-1:0]),
    .wr_entry    (wr_entry),
    .rd_en       (req_take && is_work),
    .rd_idx      (req.symbol[IDX_W-1:0]),
    .rd_in_range (in_range),
    .lookup      (lookup)
  );

  hbp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .take       (req_take && is_work),
    .take_flush (req.func == FUNC_FLUSH),
    .lookup     (lookup),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule
